### design/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int FIELD_BITS           = 31;
    localparam int OPERAND_BITS_DEFAULT = 31;
    localparam int MODULUS_RESET        = 97;

endpackage

### design/mexp_req_if.sv
`timescale 1ns / 1ps

interface mexp_req_if
    import mexp_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] base;
    logic [FIELD_BITS-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);

endinterface

### design/mexp_rsp_if.sv
`timescale 1ns / 1ps

interface mexp_rsp_if
    import mexp_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);

endinterface

### design/mexp_mulmod.sv
`timescale 1ns / 1ps

// bit-serial interleaved modular multiply: p = x * y mod m, x < m, y any w-bit value
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] x,
    input  logic [OPERAND_BITS-1:0] y,
    input  logic [OPERAND_BITS-1:0] m,
    output logic                    done,
    output logic [OPERAND_BITS-1:0] p
);

    localparam int W  = OPERAND_BITS;
    localparam int WE = OPERAND_BITS + 3;
    localparam int CW = $clog2(OPERAND_BITS + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  x_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [WE-1:0] sum;
    logic [WE-1:0] diff1;
    logic [WE-1:0] diff2;

    // 2r + bit*x is below 3m, so at most two subtractions of m
    always_comb
    begin
        sum   = {2'b00, r_reg, 1'b0} + (y_reg[W-1] ? WE'(x_reg) : WE'(0));
        diff1 = sum - WE'(m);
        diff2 = sum - {2'b00, m, 1'b0};
        if (!diff2[WE-1])
        begin
            r_next = diff2[W-1:0];
        end
        else if (!diff1[WE-1])
        begin
            r_next = diff1[W-1:0];
        end
        else
        begin
            r_next = sum[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            y_reg <= y;
            x_reg <= x;
        end
        else if (cnt_reg != '0)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign p    = r_reg;

endmodule

### design/modular_exponentiation_top.sv
`timescale 1ns / 1ps

// modular exponentiation: result = base ** exponent mod modulus
// req channel carries base and exponent, rsp channel carries result; both
// use valid/ready and move one item at a rising edge with both high.
// the user must write modulus through cfg_we/cfg_wdata only while the block
// is idle; the block does not enforce this. a value whose low OPERAND_BITS
// bits are zero is ignored. one item at a time: one pass of a bit-serial
// modular multiplier reduces the base, then OPERAND_BITS passes run the
// multiply and the square side by side, one exponent bit each; rsp.valid
// rises once the last pass is done and the output register is free.
// the result sits in an output register, so a new item is accepted while
// the previous result still waits; if the receiver stalls until the next
// result is ready, the block holds it and stops taking items.
// reset empties the block and sets modulus to 97.
module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [FIELD_BITS-1:0] cfg_wdata,
    mexp_req_if.sink              req,
    mexp_rsp_if.source            rsp
);

    localparam int W  = OPERAND_BITS;
    localparam int CW = $clog2(OPERAND_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BASE,
        S_BITS,
        S_FIN
    } state_t;

    state_t        state_reg;
    logic [W-1:0]  modulus_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  run_reg;
    logic [W-1:0]  exp_reg;
    logic [CW-1:0] bit_cnt_reg;
    logic          start_reg;
    logic          rsp_valid_reg;
    logic [W-1:0]  result_reg;

    logic [W-1:0] one_mod;
    logic [W-1:0] sq_x;
    logic         sq_done;
    logic [W-1:0] sq_p;
    logic         mul_done;
    logic [W-1:0] mul_p;
    logic         req_take;
    logic         rsp_free;

    assign one_mod  = (modulus_reg == W'(1)) ? '0 : W'(1);
    assign req_take = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // first pass reduces the base as 1 * base mod m
    assign sq_x = (state_reg == S_BASE) ? one_mod : run_reg;

    mexp_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .x     (sq_x),
        .y     (run_reg),
        .m     (modulus_reg),
        .done  (sq_done),
        .p     (sq_p)
    );

    mexp_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .x     (acc_reg),
        .y     (run_reg),
        .m     (modulus_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= W'(MODULUS_RESET);
            bit_cnt_reg   <= '0;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we && (cfg_wdata[W-1:0] != '0))
            begin
                modulus_reg <= cfg_wdata[W-1:0];
            end
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    if (sq_done)
                    begin
                        bit_cnt_reg <= '0;
                        start_reg   <= 1'b1;
                        state_reg   <= S_BITS;
                    end
                end
                S_BITS:
                begin
                    if (sq_done && mul_done)
                    begin
                        if (bit_cnt_reg == CW'(W - 1))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            bit_cnt_reg <= bit_cnt_reg + CW'(1);
                            start_reg   <= 1'b1;
                        end
                    end
                end
                S_FIN:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_take)
        begin
            run_reg <= req.base[W-1:0];
            exp_reg <= req.exponent[W-1:0];
            acc_reg <= one_mod;
        end
        else if (state_reg == S_BASE && sq_done)
        begin
            run_reg <= sq_p;
        end
        else if (state_reg == S_BITS && sq_done && mul_done)
        begin
            run_reg <= sq_p;
            if (exp_reg[0])
            begin
                acc_reg <= mul_p;
            end
            exp_reg <= {1'b0, exp_reg[W-1:1]};
        end
        if (state_reg == S_FIN && rsp_free)
        begin
            result_reg <= acc_reg;
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.result = FIELD_BITS'(result_reg);

endmodule
